@@ rtl/core/ssrm_pkg.sv @@
// Shared types and constants for the slot scale / round / modular-reduce codec.
// No dependencies.
`default_nettype none

package ssrm_pkg;

  localparam int DATA_W  = 64;
  localparam int MOD_W   = 63;
  localparam int COEFF_W = 62;
  localparam int SLOT_W  = 15;
  localparam int POS_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_SLOTS = 32768;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_DEGREE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd3;

  localparam logic [MOD_W-1:0] MODULUS_RESET     = 63'h4000_0000_0000_0000;
  localparam logic [MOD_W-1:0] SCALE_RESET       = 63'h0000_0100_0000_0000;
  localparam logic [POS_W-1:0] HALF_DEGREE_RESET = 16'h8000;
  localparam logic [POS_W-1:0] SLOT_COUNT_RESET  = 16'h8000;

  // Saturation limits as magnitudes.
  localparam logic [DATA_W-1:0] SAT_POS_MAG = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG_MAG = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic op;
    logic act;
    logic neg;
    logic ovf;
  } lane_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/ssrm_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Uses no package; divisor must be held steady while transactions are in flight.
`default_nettype none

module ssrm_div_pipe #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 63,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [DEN_W-1:0]  out_rem,
  output logic [SIDE_W-1:0] out_side
);

  logic [NUM_W:1]    vld_q;
  logic [NUM_W-1:0]  nq_q   [1:NUM_W];
  logic [DEN_W-1:0]  rem_q  [1:NUM_W];
  logic [SIDE_W-1:0] side_q [1:NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              valid_src;
    logic [NUM_W-1:0]  nq_src;
    logic [DEN_W-1:0]  rem_src;
    logic [SIDE_W-1:0] side_src;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign valid_src = in_valid;
      assign nq_src    = in_num;
      assign rem_src   = '0;
      assign side_src  = in_side;
    end else begin : g_rest
      assign valid_src = vld_q[k];
      assign nq_src    = nq_q[k];
      assign rem_src   = rem_q[k];
      assign side_src  = side_q[k];
    end

    // Bring down the next numerator bit; the quotient bit fills in from the bottom.
    assign trial = {rem_src, nq_src[NUM_W-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= valid_src;
      end
      nq_q[k+1]   <= {nq_src[NUM_W-2:0], ge};
      rem_q[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      side_q[k+1] <= side_src;
    end
  end

  assign out_valid = vld_q[NUM_W];
  assign out_quo   = nq_q[NUM_W];
  assign out_rem   = rem_q[NUM_W];
  assign out_side  = side_q[NUM_W];

endmodule

`default_nettype wire

@@ rtl/core/ssrm_lane.sv @@
// One value lane: scale, round, saturate, reduce, lift, divide, round, saturate.
// Depends on ssrm_pkg and ssrm_div_pipe.
`default_nettype none

module ssrm_lane #(
  parameter int FRAC_BITS = 32,
  parameter int SIDE_W    = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_op,
  input  logic                        in_act,
  input  logic [ssrm_pkg::DATA_W-1:0]  x,
  input  logic [ssrm_pkg::COEFF_W-1:0] c,
  input  logic [ssrm_pkg::MOD_W-1:0]   modulus,
  input  logic [ssrm_pkg::MOD_W-1:0]   scale,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [ssrm_pkg::COEFF_W-1:0] out_coeff,
  output logic [ssrm_pkg::DATA_W-1:0]  out_value,
  output logic                        out_ovf,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int PROD_W  = 127;
  localparam int CTL_W   = $bits(ssrm_pkg::lane_ctl_t);
  localparam int NUM_W   = ssrm_pkg::COEFF_W + FRAC_BITS;
  localparam int QR_W    = NUM_W + 1;
  localparam int SAT_W   = (QR_W > 65) ? QR_W : 65;
  localparam int MSIDE_W = CTL_W + SIDE_W;
  localparam int DSIDE_W = ssrm_pkg::COEFF_W + CTL_W + SIDE_W;

  // s1: sign and magnitude
  logic                        s1_valid;
  ssrm_pkg::lane_ctl_t         s1_ctl;
  logic [63:0]                 s1_mag;
  logic [ssrm_pkg::COEFF_W-1:0] s1_c;
  logic [SIDE_W-1:0]           s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_ctl.op  <= in_op;
    s1_ctl.act <= in_act;
    s1_ctl.neg <= x[63];
    s1_ctl.ovf <= 1'b0;
    s1_mag     <= x[63] ? (64'd0 - x) : x;
    s1_c       <= c;
    s1_side    <= in_side;
  end

  // s2: four partial products, 32-bit magnitude halves by 32-bit and 31-bit scale halves
  logic                        s2_valid;
  ssrm_pkg::lane_ctl_t         s2_ctl;
  logic [63:0]                 s2_p00, s2_p01, s2_p10, s2_p11;
  logic [ssrm_pkg::COEFF_W-1:0] s2_c;
  logic [SIDE_W-1:0]           s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_ctl  <= s1_ctl;
    s2_p00  <= {32'd0, s1_mag[31:0]}  * {32'd0, scale[31:0]};
    s2_p01  <= {32'd0, s1_mag[31:0]}  * {33'd0, scale[62:32]};
    s2_p10  <= {32'd0, s1_mag[63:32]} * {32'd0, scale[31:0]};
    s2_p11  <= {32'd0, s1_mag[63:32]} * {33'd0, scale[62:32]};
    s2_c    <= s1_c;
    s2_side <= s1_side;
  end

  // s3: sum partial products
  logic                        s3_valid;
  ssrm_pkg::lane_ctl_t         s3_ctl;
  logic [PROD_W-1:0]           s3_prod;
  logic [ssrm_pkg::COEFF_W-1:0] s3_c;
  logic [SIDE_W-1:0]           s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_ctl  <= s2_ctl;
    s3_prod <= PROD_W'(s2_p00) + (PROD_W'(s2_p01) << 32) + (PROD_W'(s2_p10) << 32)
             + (PROD_W'(s2_p11) << 64);
    s3_c    <= s2_c;
    s3_side <= s2_side;
  end

  // s4: round half away from zero on the magnitude, drop fraction bits
  logic [PROD_W-1:0] rnd_val;

  if (FRAC_BITS > 0) begin : g_round
    assign rnd_val = (s3_prod + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  end else begin : g_noround
    assign rnd_val = s3_prod;
  end

  logic                        s4_valid;
  ssrm_pkg::lane_ctl_t         s4_ctl;
  logic [PROD_W-1:0]           s4_rnd;
  logic [ssrm_pkg::COEFF_W-1:0] s4_c;
  logic [SIDE_W-1:0]           s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_ctl  <= s3_ctl;
    s4_rnd  <= rnd_val;
    s4_c    <= s3_c;
    s4_side <= s3_side;
  end

  // s5: saturate and pick the value to reduce
  logic [63:0]         enc_lim;
  logic                enc_sat;
  ssrm_pkg::lane_ctl_t s5_ctl_next;

  always_comb begin
    enc_lim     = s4_ctl.neg ? ssrm_pkg::SAT_NEG_MAG : ssrm_pkg::SAT_POS_MAG;
    enc_sat     = s4_rnd > PROD_W'(enc_lim);
    s5_ctl_next = s4_ctl;
    s5_ctl_next.ovf = (s4_ctl.op == ssrm_pkg::OP_ENCODE) && enc_sat;
  end

  logic                s5_valid;
  ssrm_pkg::lane_ctl_t s5_ctl;
  logic [63:0]         s5_val;
  logic [SIDE_W-1:0]   s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_ctl  <= s5_ctl_next;
    if (s4_ctl.op == ssrm_pkg::OP_DECODE) begin
      s5_val <= {2'b00, s4_c};
    end else begin
      s5_val <= enc_sat ? enc_lim : s4_rnd[63:0];
    end
    s5_side <= s4_side;
  end

  // Reduce mod modulus
  logic                      m_valid;
  logic [ssrm_pkg::MOD_W-1:0] m_rem;
  logic [MSIDE_W-1:0]        m_side;
  ssrm_pkg::lane_ctl_t       m_ctl;
  logic [SIDE_W-1:0]         m_user;

  ssrm_div_pipe #(
    .NUM_W  (64),
    .DEN_W  (ssrm_pkg::MOD_W),
    .SIDE_W (MSIDE_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_valid),
    .in_num    (s5_val),
    .den       (modulus),
    .in_side   ({s5_ctl, s5_side}),
    .out_valid (m_valid),
    .out_quo   (),
    .out_rem   (m_rem),
    .out_side  (m_side)
  );

  assign {m_ctl, m_user} = m_side;

  // s6: fold negatives for encode, centred lift for decode
  logic [ssrm_pkg::MOD_W-1:0] mod_sub;
  logic                      dec_neg;
  logic                      use_sub;
  ssrm_pkg::lane_ctl_t       s6_ctl_next;

  always_comb begin
    mod_sub     = modulus - m_rem;
    dec_neg     = m_rem > (modulus >> 1);
    s6_ctl_next = m_ctl;
    if (m_ctl.op == ssrm_pkg::OP_DECODE) begin
      use_sub         = dec_neg;
      s6_ctl_next.neg = dec_neg;
    end else begin
      use_sub = m_ctl.neg && (m_rem != '0);
    end
  end

  logic                        s6_valid;
  ssrm_pkg::lane_ctl_t         s6_ctl;
  logic [ssrm_pkg::COEFF_W-1:0] s6_lift;
  logic [SIDE_W-1:0]           s6_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= m_valid;
    end
    s6_ctl  <= s6_ctl_next;
    s6_lift <= use_sub ? mod_sub[ssrm_pkg::COEFF_W-1:0] : m_rem[ssrm_pkg::COEFF_W-1:0];
    s6_side <= m_user;
  end

  // Divide lifted magnitude (as fixed point) by the scale
  logic [ssrm_pkg::MOD_W-1:0]   scale_div;
  logic                        d_valid;
  logic [NUM_W-1:0]            d_quo;
  logic [ssrm_pkg::MOD_W-1:0]   d_rem;
  logic [DSIDE_W-1:0]          d_side;
  logic [ssrm_pkg::COEFF_W-1:0] d_lift;
  ssrm_pkg::lane_ctl_t         d_ctl;
  logic [SIDE_W-1:0]           d_user;

  assign scale_div = (scale == '0) ? ssrm_pkg::MOD_W'(1) : scale;

  ssrm_div_pipe #(
    .NUM_W  (NUM_W),
    .DEN_W  (ssrm_pkg::MOD_W),
    .SIDE_W (DSIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s6_valid),
    .in_num    (NUM_W'(s6_lift) << FRAC_BITS),
    .den       (scale_div),
    .in_side   ({s6_lift, s6_ctl, s6_side}),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_rem   (d_rem),
    .out_side  (d_side)
  );

  assign {d_lift, d_ctl, d_user} = d_side;

  // s7: round to nearest, ties up
  logic                        s7_valid;
  ssrm_pkg::lane_ctl_t         s7_ctl;
  logic [QR_W-1:0]             s7_q;
  logic [ssrm_pkg::COEFF_W-1:0] s7_lift;
  logic [SIDE_W-1:0]           s7_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= d_valid;
    end
    s7_ctl  <= d_ctl;
    s7_q    <= QR_W'(d_quo) + QR_W'(d_rem >= (scale_div - d_rem));
    s7_lift <= d_lift;
    s7_side <= d_user;
  end

  // s8: saturate, apply sign, gate inactive slots
  logic [SAT_W-1:0] q_ext;
  logic [63:0]      dec_lim;
  logic             dec_sat;
  logic [63:0]      dec_mag;
  logic [63:0]      dec_val;
  logic             is_enc;
  logic             is_dec;

  always_comb begin
    q_ext   = SAT_W'(s7_q);
    dec_lim = s7_ctl.neg ? ssrm_pkg::SAT_NEG_MAG : ssrm_pkg::SAT_POS_MAG;
    dec_sat = q_ext > SAT_W'(dec_lim);
    dec_mag = dec_sat ? dec_lim : q_ext[63:0];
    dec_val = s7_ctl.neg ? (64'd0 - dec_mag) : dec_mag;
    is_enc  = s7_ctl.act && (s7_ctl.op == ssrm_pkg::OP_ENCODE);
    is_dec  = s7_ctl.act && (s7_ctl.op == ssrm_pkg::OP_DECODE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s7_valid;
    end
    out_coeff <= is_enc ? s7_lift : '0;
    out_value <= is_dec ? dec_val : '0;
    out_ovf   <= (is_enc && s7_ctl.ovf) || (is_dec && dec_sat);
    out_side  <= s7_side;
  end

endmodule

`default_nettype wire

@@ rtl/core/slot_scale_round_mod_codec_unit.sv @@
// Top level of the slot codec: configuration registers and two value lanes.
// Depends on ssrm_pkg and ssrm_lane.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------------
//   command  | start, busy         | opcode, slot_index, real_in, imag_in,
//            |                     | coeff_low_in, coeff_high_in
//   result   | done (strobe)       | coeff_low_out, coeff_high_out, low_position,
//            |                     | high_position, real_out, imag_out, overflow_flag
//   config   | cfg_write           | cfg_addr, cfg_data
//
// One transaction is taken every cycle outside reset; done pulses once it has passed
// every lane register. Most of the pipeline depth lies in the two bit-serial
// pipelined dividers: 64 stages for the modular reduction, 62 + FRAC_BITS for the
// decode division. busy is high only during reset; reset empties the pipeline and
// restores the register defaults. The result side has no backpressure.
`default_nettype none

module slot_scale_round_mod_codec_unit #(
  parameter int FRAC_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 opcode,
  input  logic [ssrm_pkg::SLOT_W-1:0]          slot_index,
  input  logic signed [ssrm_pkg::DATA_W-1:0]   real_in,
  input  logic signed [ssrm_pkg::DATA_W-1:0]   imag_in,
  input  logic [ssrm_pkg::COEFF_W-1:0]         coeff_low_in,
  input  logic [ssrm_pkg::COEFF_W-1:0]         coeff_high_in,
  output logic                                 done,
  output logic [ssrm_pkg::COEFF_W-1:0]         coeff_low_out,
  output logic [ssrm_pkg::COEFF_W-1:0]         coeff_high_out,
  output logic [ssrm_pkg::SLOT_W-1:0]          low_position,
  output logic [ssrm_pkg::POS_W-1:0]           high_position,
  output logic signed [ssrm_pkg::DATA_W-1:0]   real_out,
  output logic signed [ssrm_pkg::DATA_W-1:0]   imag_out,
  output logic                                 overflow_flag,
  input  logic                                 cfg_write,
  input  logic [ssrm_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [ssrm_pkg::MOD_W-1:0]           cfg_data
);

  logic [ssrm_pkg::MOD_W-1:0] modulus_value;
  logic [ssrm_pkg::MOD_W-1:0] scale_value;
  logic [ssrm_pkg::POS_W-1:0] half_degree;
  logic [ssrm_pkg::POS_W-1:0] slot_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_value <= ssrm_pkg::MODULUS_RESET;
      scale_value   <= ssrm_pkg::SCALE_RESET;
      half_degree   <= ssrm_pkg::HALF_DEGREE_RESET;
      slot_count    <= ssrm_pkg::SLOT_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_addr)
        ssrm_pkg::CFG_MODULUS:     modulus_value <= cfg_data;
        ssrm_pkg::CFG_SCALE:       scale_value   <= cfg_data;
        ssrm_pkg::CFG_HALF_DEGREE: half_degree   <= cfg_data[ssrm_pkg::POS_W-1:0];
        ssrm_pkg::CFG_SLOT_COUNT:  slot_count    <= cfg_data[ssrm_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  logic                      accept;
  logic                      active;
  logic [ssrm_pkg::MOD_W-1:0] mod_eff;
  logic [ssrm_pkg::POS_W-1:0] high_pos;

  assign busy     = rst;
  assign accept   = start && !busy;
  // A zero modulus behaves as one.
  assign mod_eff  = (modulus_value == '0) ? ssrm_pkg::MOD_W'(1) : modulus_value;
  assign active   = (ssrm_pkg::POS_W'(slot_index) < slot_count)
                 && (ssrm_pkg::POS_W'(slot_index) < half_degree)
                 && (17'(slot_index) < 17'(ssrm_pkg::MAX_SLOTS));
  assign high_pos = ssrm_pkg::POS_W'(slot_index) + half_degree;

  logic                               lo_valid, hi_valid;
  logic                               lo_ovf, hi_ovf;
  logic [ssrm_pkg::DATA_W-1:0]         lo_value, hi_value;

  ssrm_lane #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (ssrm_pkg::SLOT_W)
  ) u_lane_real (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_op     (opcode),
    .in_act    (active),
    .x         (real_in),
    .c         (coeff_low_in),
    .modulus   (mod_eff),
    .scale     (scale_value),
    .in_side   (slot_index),
    .out_valid (lo_valid),
    .out_coeff (coeff_low_out),
    .out_value (lo_value),
    .out_ovf   (lo_ovf),
    .out_side  (low_position)
  );

  ssrm_lane #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (ssrm_pkg::POS_W)
  ) u_lane_imag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_op     (opcode),
    .in_act    (active),
    .x         (imag_in),
    .c         (coeff_high_in),
    .modulus   (mod_eff),
    .scale     (scale_value),
    .in_side   (high_pos),
    .out_valid (hi_valid),
    .out_coeff (coeff_high_out),
    .out_value (hi_value),
    .out_ovf   (hi_ovf),
    .out_side  (high_position)
  );

  assign done          = lo_valid && hi_valid;
  assign real_out      = lo_value;
  assign imag_out      = hi_value;
  assign overflow_flag = lo_ovf || hi_ovf;

endmodule

`default_nettype wire

@@ tb/slot_scale_round_mod_codec_unit_test.sv @@
// Self-checking testbench for slot_scale_round_mod_codec_unit: scale, round and reduce
// on encode, and centred lift and divide on decode, checked against an in-bench predictor.
// Depends on ssrm_pkg and the codec RTL.
`timescale 1ns / 1ps

module slot_scale_round_mod_codec_unit_test;

  localparam int FRAC = 32;
  localparam int LATENCY = 134 + FRAC;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;
  localparam logic [61:0] COEFF_MASK = {62{1'b1}};

  typedef struct {
    logic                        op;
    logic [ssrm_pkg::SLOT_W-1:0] slot;
    logic [63:0]                 re;
    logic [63:0]                 im;
    logic [61:0]                 cl;
    logic [61:0]                 ch;
  } slot_cmd_t;

  typedef struct {
    logic [61:0] cl;
    logic [61:0] ch;
    logic [14:0] lpos;
    logic [15:0] hpos;
    logic [63:0] re;
    logic [63:0] im;
    logic        ovf;
  } slot_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = 1'b0;
  logic [ssrm_pkg::SLOT_W-1:0] slot_index = '0;
  logic signed [63:0] real_in = '0;
  logic signed [63:0] imag_in = '0;
  logic [61:0] coeff_low_in = '0;
  logic [61:0] coeff_high_in = '0;
  logic done;
  logic [61:0] coeff_low_out, coeff_high_out;
  logic [14:0] low_position;
  logic [15:0] high_position;
  logic signed [63:0] real_out, imag_out;
  logic overflow_flag;
  logic cfg_write = 1'b0;
  logic [ssrm_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [ssrm_pkg::MOD_W-1:0] cfg_data = '0;

  slot_scale_round_mod_codec_unit #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .slot_index(slot_index), .real_in(real_in), .imag_in(imag_in),
    .coeff_low_in(coeff_low_in), .coeff_high_in(coeff_high_in),
    .done(done), .coeff_low_out(coeff_low_out), .coeff_high_out(coeff_high_out),
    .low_position(low_position), .high_position(high_position),
    .real_out(real_out), .imag_out(imag_out), .overflow_flag(overflow_flag),
    .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [62:0] mod_reg = ssrm_pkg::MODULUS_RESET;
  logic [62:0] scale_reg = ssrm_pkg::SCALE_RESET;
  logic [15:0] half_deg_reg = ssrm_pkg::HALF_DEGREE_RESET;
  logic [15:0] slot_cnt_reg = ssrm_pkg::SLOT_COUNT_RESET;

  slot_cmd_t pending_cmds[$];
  slot_res_t expected_slots[$];
  int gap_left = 0;
  bit no_idle = 0;
  bit hold_sender = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_encode = 0;
  int n_ovf = 0;

  function automatic logic [63:0] clamp_mag(logic [127:0] v, bit neg, inout bit ovf);
    logic [127:0] lim;
    lim = neg ? {64'd0, NEG_LIM} : {64'd0, POS_LIM};
    if (v > lim) begin
      ovf = 1;
      return lim[63:0];
    end
    return v[63:0];
  endfunction

  function automatic logic [61:0] scale_reduce(logic [63:0] x, logic [63:0] md,
                                                inout bit ovf);
    bit neg;
    logic [63:0] mag, r;
    logic [127:0] p;
    neg = x[63];
    mag = neg ? -x : x;
    p = ({64'd0, mag} * {65'd0, scale_reg} + (128'd1 << (FRAC - 1))) >> FRAC;
    mag = clamp_mag(p, neg, ovf);
    r = mag % md;
    if (neg && r != 0) r = md - r;
    return r[61:0];
  endfunction

  function automatic logic [63:0] lift_divide(logic [61:0] c, logic [63:0] md,
                                              logic [63:0] sc, inout bit ovf);
    bit neg;
    logic [63:0] red, mag;
    logic [127:0] n, q, rem;
    red = {2'b0, c} % md;
    neg = red > md / 2;
    mag = neg ? md - red : red;
    n = {64'd0, mag} << FRAC;
    q = n / {64'd0, sc};
    rem = n % {64'd0, sc};
    if (rem >= {64'd0, sc} - rem) q = q + 1;
    mag = clamp_mag(q, neg, ovf);
    return neg ? -mag : mag;
  endfunction

  function automatic slot_res_t predict_slot(slot_cmd_t c);
    slot_res_t r;
    logic [63:0] md, sc;
    bit ovf;
    bit active;
    ovf = 0;
    md = (mod_reg == 0) ? 64'd1 : {1'b0, mod_reg};
    sc = (scale_reg == 0) ? 64'd1 : {1'b0, scale_reg};
    active = c.slot < slot_cnt_reg && c.slot < half_deg_reg;
    r.cl = '0; r.ch = '0; r.re = '0; r.im = '0;
    if (active && c.op == ssrm_pkg::OP_ENCODE) begin
      r.cl = scale_reduce(c.re, md, ovf) & COEFF_MASK;
      r.ch = scale_reduce(c.im, md, ovf) & COEFF_MASK;
    end else if (active) begin
      r.re = lift_divide(c.cl, md, sc, ovf);
      r.im = lift_divide(c.ch, md, sc, ovf);
    end
    r.lpos = c.slot;
    r.hpos = {1'b0, c.slot} + half_deg_reg;
    r.ovf = ovf;
    return r;
  endfunction

  task automatic check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", fname, exp_v, act_v);
    end
  endtask

  // driver: present the head of the queue, idle in reset, while held, when a gap is pending or the queue is empty
  always @(negedge clk) begin
    if (rst || hold_sender || gap_left > 0 || pending_cmds.size() == 0) begin
      start <= 1'b0;
      if (gap_left > 0) gap_left <= gap_left - 1;
    end else begin
      start <= 1'b1;
      opcode <= pending_cmds[0].op;
      slot_index <= pending_cmds[0].slot;
      real_in <= pending_cmds[0].re;
      imag_in <= pending_cmds[0].im;
      coeff_low_in <= pending_cmds[0].cl;
      coeff_high_in <= pending_cmds[0].ch;
    end
  end

  // monitor: predict on accept, compare on done, watch for a stall
  always @(posedge clk) begin
    slot_res_t e;
    slot_cmd_t c;
    int r;
    bit moved;
    moved = 0;
    if (!rst) begin
      if (start && !busy) begin
        c = pending_cmds.pop_front();
        expected_slots.push_back(predict_slot(c));
        n_accepted++;
        if (c.op == ssrm_pkg::OP_ENCODE) n_encode++;
        moved = 1;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) gap_left <= 0;
        else if (r < 95) gap_left <= $urandom_range(1, 3);
        else gap_left <= $urandom_range(10, 40);
      end
      if (done) begin
        moved = 1;
        n_results++;
        if (overflow_flag) n_ovf++;
        if (expected_slots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: result with no transaction pending");
        end else begin
          e = expected_slots.pop_front();
          check_field("coeff_low_out", 64'(e.cl), 64'(coeff_low_out));
          check_field("coeff_high_out", 64'(e.ch), 64'(coeff_high_out));
          check_field("low_position", 64'(e.lpos), 64'(low_position));
          check_field("high_position", 64'(e.hpos), 64'(high_position));
          check_field("real_out", e.re, real_out);
          check_field("imag_out", e.im, imag_out);
          check_field("overflow_flag", 64'(e.ovf), 64'(overflow_flag));
        end
      end
      if (moved) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return v;
      1: return {{24{v[63]}}, v[39:0]};
      2: return {{40{v[63]}}, v[23:0]};
      3: return $urandom_range(0, 1) ? NEG_LIM : POS_LIM;
      4: return $urandom_range(0, 1) ? 64'(signed'(-1)) : 64'd1 << $urandom_range(0, 62);
      default: return {{12{v[63]}}, v[51:0]};
    endcase
  endfunction

  function automatic logic [61:0] pick_coeff();
    logic [63:0] v, md;
    v = {$urandom, $urandom};
    md = (mod_reg == 0) ? 64'd1 : {1'b0, mod_reg};
    case ($urandom_range(0, 4))
      0: return v[61:0];
      1: return 62'(v % md);
      2: return 62'(md - 1 - v[3:0]);
      3: return 62'((md / 2) + v[1:0] - 1);
      default: return 62'(v[19:0]);
    endcase
  endfunction

  function automatic slot_cmd_t random_cmd();
    slot_cmd_t c;
    int lim;
    c.op = $urandom_range(0, 1) ? ssrm_pkg::OP_DECODE : ssrm_pkg::OP_ENCODE;
    lim = (slot_cnt_reg < half_deg_reg) ? slot_cnt_reg : half_deg_reg;
    if (lim > 32767) lim = 32767;
    case ($urandom_range(0, 3))
      0: c.slot = 15'($urandom);
      1: c.slot = 15'(lim - 1 + $urandom_range(0, 2));
      default: c.slot = (lim > 0) ? 15'($urandom_range(0, lim - 1)) : 15'($urandom);
    endcase
    c.re = pick_value();
    c.im = pick_value();
    c.cl = pick_coeff();
    c.ch = pick_coeff();
    return c;
  endfunction

  task automatic write_reg(logic [ssrm_pkg::CFG_IDX_W-1:0] idx,
                           logic [ssrm_pkg::MOD_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      ssrm_pkg::CFG_MODULUS: mod_reg = val;
      ssrm_pkg::CFG_SCALE: scale_reg = val;
      ssrm_pkg::CFG_HALF_DEGREE: half_deg_reg = val[15:0];
      default: slot_cnt_reg = val[15:0];
    endcase
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && expected_slots.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic add_cmd(logic op, logic [14:0] s, logic [63:0] a, logic [63:0] b,
                         logic [61:0] x, logic [61:0] y);
    slot_cmd_t c;
    c.op = op; c.slot = s; c.re = a; c.im = b; c.cl = x; c.ch = y;
    pending_cmds.push_back(c);
  endtask

  task automatic run_phase(logic [62:0] md, logic [62:0] sc, logic [15:0] hd,
                           logic [15:0] cnt, int n);
    drain();
    write_reg(ssrm_pkg::CFG_MODULUS, md);
    write_reg(ssrm_pkg::CFG_SCALE, sc);
    write_reg(ssrm_pkg::CFG_HALF_DEGREE, 63'(hd));
    write_reg(ssrm_pkg::CFG_SLOT_COUNT, 63'(cnt));
    no_idle = $urandom_range(0, 3) == 0;
    for (int i = 0; i < n; i++) pending_cmds.push_back(random_cmd());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed checks at reset values: extremes, ties, sign handling
    add_cmd(ssrm_pkg::OP_ENCODE, 15'd0, 64'd0, 64'd0, '0, '0);
    add_cmd(ssrm_pkg::OP_ENCODE, 15'd1, 64'h1_0000_0000, -64'sh1_0000_0000, '0, '0);
    add_cmd(ssrm_pkg::OP_ENCODE, 15'd2, POS_LIM, NEG_LIM, '0, '0);
    add_cmd(ssrm_pkg::OP_ENCODE, 15'd3, 64'd128, -64'sd128, '0, '0);
    add_cmd(ssrm_pkg::OP_ENCODE, 15'd4, 64'd1, -64'sd1, '0, '0);
    add_cmd(ssrm_pkg::OP_ENCODE, 15'h7FFF, 64'hFFFF_FFFF, 64'd5, '0, '0);
    add_cmd(ssrm_pkg::OP_DECODE, 15'd5, '0, '0, '0, COEFF_MASK);
    add_cmd(ssrm_pkg::OP_DECODE, 15'd6, '0, '0, 62'h2000_0000_0000_0000,
            62'h2000_0000_0000_0001);
    add_cmd(ssrm_pkg::OP_DECODE, 15'd7, '0, '0, 62'd1 << 40, (62'd1 << 39) + 62'd1);
    add_cmd(ssrm_pkg::OP_DECODE, 15'd8, '0, '0, 62'd128, 62'd127);
    add_cmd(ssrm_pkg::OP_DECODE, 15'h7FFF, POS_LIM, NEG_LIM, COEFF_MASK, 62'd1);
    add_cmd(ssrm_pkg::OP_DECODE, 15'h4000, '0, '0, 62'h1555_5555_5555_5555,
            62'h2AAA_AAAA_AAAA_AAAA);
    for (int i = 0; i < 200; i++) pending_cmds.push_back(random_cmd());

    // make the sender wait for every outstanding result once
    wait (pending_cmds.size() < 100);
    hold_sender = 1;
    wait (expected_slots.size() == 0);
    @(negedge clk);
    hold_sender = 0;

    run_phase(63'h4000_0000_0000_0000, 63'd1, 16'd32768, 16'd32768, 180);
    run_phase(63'd2, 63'h4000_0000_0000_0000, 16'd1, 16'd32768, 150);
    run_phase(63'd65537, 63'd1 << 20, 16'd256, 16'd100, 200);
    run_phase(63'd0, 63'd0, 16'd65535, 16'd65535, 150);
    run_phase(63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 16'd0, 16'd0, 120);
    run_phase(63'h3FFF_FFFF_FFFF_FFC5, 63'd1 << 50, 16'd4096, 16'd3000, 200);
    run_phase(63'd97, 63'd3, 16'd16, 16'd1, 150);
    run_phase(63'd1 << 45, 63'd1 << 32, 16'd32768, 16'd32767, 200);
    run_phase(63'h0123_4567_89AB_CDEF, 63'd12345, 16'd40000, 16'd20000, 200);

    wait (pending_cmds.size() == 0 && expected_slots.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (expected_slots.size() != 0) mismatches++;
    $display("Covered %0d transactions (%0d encode, %0d decode) over ten register settings;",
             n_accepted, n_encode, n_accepted - n_encode);
    $display("%0d results checked, %0d saturated, %0d mismatches.",
             n_results, n_ovf, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ssrm_pkg.sv
rtl/core/ssrm_div_pipe.sv
rtl/core/ssrm_lane.sv
rtl/core/slot_scale_round_mod_codec_unit.sv
tb/slot_scale_round_mod_codec_unit_test.sv
